FILE: hdl/apa_pkg.sv
`timescale 1ns / 1ps

package apa_pkg;

   localparam int RATIO_FRAC   = 15;
   localparam int COEF_FRAC    = 30;
   localparam int QUOT_BITS    = 16;
   localparam int ACC_BITS     = 32;
   localparam int SQ_BITS      = 31;
   localparam int HORNER_STEPS = 5;
   localparam int NUM_COEFS    = HORNER_STEPS + 1;

   // pi scaled by 2^62
   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

   typedef logic signed [ACC_BITS-1:0] coef_type;

   // odd minimax coefficients a1 .. a11 in signed q30
   localparam coef_type COEF_Q30 [NUM_COEFS] = '{
      32'sd1073717407,
      -32'sd357151731,
      32'sd207815708,
      -32'sd125018841,
      32'sd56536068,
      -32'sd12585543
   };

   typedef struct packed {
      logic zero;
      logic swap;
      logic neg;
      logic x_neg;
      logic y_neg;
   } side_type;

endpackage

FILE: hdl/apa_req_if.sv
`timescale 1ns / 1ps

interface apa_req_if #(
   parameter int WIDTH = 16
) ();

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] y_value;
   logic signed [WIDTH-1:0] x_value;

   modport source (output valid, output y_value, output x_value, input ready);
   modport sink (input valid, input y_value, input x_value, output ready);

endinterface

FILE: hdl/apa_rsp_if.sv
`timescale 1ns / 1ps

interface apa_rsp_if #(
   parameter int WIDTH = 16
) ();

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink (input valid, input angle, output ready);

endinterface

FILE: hdl/atan2_polynomial_approx_core.sv
`timescale 1ns / 1ps

// channel    direction  payload                      width
// req_chan   in         y_value, x_value             INPUT_WIDTH each, signed
// rsp_chan   out        angle (q3.ANGLE_FRAC_BITS)   ANGLE_FRAC_BITS + 3, signed
//
// one transfer in and one out per cycle unless held; stages from input to output
// (two operand stages, 16 one-bit divider stages, squaring, 5 horner multiply
// stages, final multiply, quadrant correction). a one-entry skid register after
// the last stage lets a result wait while the pipeline moves on; when it is
// full the whole pipeline holds. synchronous reset clears the valid bits only.

module atan2_polynomial_approx_core #(
   parameter int INPUT_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input logic        clock,
   input logic        reset,
   apa_req_if.sink    req_chan,
   apa_rsp_if.source  rsp_chan
);

   import apa_pkg::*;

   localparam int W   = INPUT_WIDTH;
   localparam int AW  = ANGLE_FRAC_BITS + 3;
   localparam int NW  = W + RATIO_FRAC;
   localparam int MSH = RATIO_FRAC + COEF_FRAC - ANGLE_FRAC_BITS;
   localparam int PW  = ACC_BITS + SQ_BITS + 1;
   localparam int MPW = QUOT_BITS + 1 + ACC_BITS;
   localparam int NS  = 5 + QUOT_BITS + HORNER_STEPS;

   localparam int ST_R = NS - 1;

   localparam logic [AW-1:0] PI_Q =
      AW'((PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS));
   localparam logic [AW-1:0] HALF_PI_Q =
      AW'((PI_Q62 + (64'd1 << (62 - ANGLE_FRAC_BITS))) >> (63 - ANGLE_FRAC_BITS));

   localparam logic signed [PW-1:0]  HALF_C = PW'(1) << (COEF_FRAC - 1);
   localparam logic signed [MPW-1:0] HALF_M = MPW'(1) << (MSH - 1);

   logic          en;
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;

   // operand stage
   logic [W-1:0] y_u;
   logic [W-1:0] x_u;
   logic [W-1:0] ay_in;
   logic [W-1:0] ax_in;
   logic [W-1:0] ay_ff;
   logic [W-1:0] ax_ff;
   side_type     aside_in;
   side_type     aside_ff;

   // dividend stage
   logic [W-1:0]  num_b;
   logic [W-1:0]  den_b;
   logic [NW-1:0] bn_in;
   logic [NW-1:0] bn_ff;
   logic [W-1:0]  bden_ff;
   side_type      bside_in;
   side_type      bside_ff;

   // divider stages
   logic [W-1:0]         drem_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] dlow_ff [QUOT_BITS];
   logic [W-1:0]         dden_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] dquo_ff [QUOT_BITS];
   side_type             dside_ff [QUOT_BITS];

   // squaring stage
   logic [ACC_BITS-1:0]  sq_full;
   logic [SQ_BITS-1:0]   s_ff;
   logic [QUOT_BITS-1:0] sq_q_ff;
   side_type             sside_ff;

   // horner stages
   coef_type             hacc_ff [HORNER_STEPS];
   logic [SQ_BITS-1:0]   hs_ff [HORNER_STEPS];
   logic [QUOT_BITS-1:0] hq_ff [HORNER_STEPS];
   side_type             hside_ff [HORNER_STEPS];

   // magnitude stage
   logic signed [MPW-1:0] mprod;
   logic signed [MPW-1:0] mrnd;
   logic [AW-1:0]         m_ff;
   side_type              mside_ff;

   // quadrant stage
   logic [AW-1:0] sgn_m;
   logic [AW-1:0] ang_in;
   logic [AW-1:0] ang_ff;

   // skid register
   logic          skid_v_ff;
   logic          skid_v_in;
   logic [AW-1:0] skid_ff;

   assign en             = !skid_v_ff;
   assign req_chan.ready = en && !reset;

   always_comb begin
      valid_in = {valid_ff[NS-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // operand stage
   always_comb begin
      y_u            = req_chan.y_value;
      x_u            = req_chan.x_value;
      ay_in          = y_u[W-1] ? (~y_u + 1'b1) : y_u;
      ax_in          = x_u[W-1] ? (~x_u + 1'b1) : x_u;
      aside_in       = '0;
      aside_in.y_neg = y_u[W-1];
      aside_in.x_neg = x_u[W-1];
      aside_in.neg   = y_u[W-1] != x_u[W-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ay_ff    <= ay_in;
         ax_ff    <= ax_in;
         aside_ff <= aside_in;
      end
   end

   // dividend stage, rounding term folded in
   always_comb begin
      bside_in      = aside_ff;
      bside_in.swap = ax_ff < ay_ff;
      bside_in.zero = (ax_ff == '0) && (ay_ff == '0);
      num_b         = bside_in.swap ? ax_ff : ay_ff;
      den_b         = bside_in.swap ? ay_ff : ax_ff;
      bn_in         = {num_b, {RATIO_FRAC{1'b0}}} + NW'(den_b >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bn_ff    <= bn_in;
         bden_ff  <= den_b;
         bside_ff <= bside_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
      logic [W-1:0]         rem_src;
      logic [QUOT_BITS-1:0] low_src;
      logic [W-1:0]         den_src;
      logic [QUOT_BITS-1:0] quo_src;
      side_type             side_src;
      logic [W:0]           trial;
      logic [W:0]           diff;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_src  = {1'b0, bn_ff[NW-1:QUOT_BITS]};
         assign low_src  = bn_ff[QUOT_BITS-1:0];
         assign den_src  = bden_ff;
         assign quo_src  = '0;
         assign side_src = bside_ff;
      end else begin : g_next
         assign rem_src  = drem_ff[k-1];
         assign low_src  = dlow_ff[k-1];
         assign den_src  = dden_ff[k-1];
         assign quo_src  = dquo_ff[k-1];
         assign side_src = dside_ff[k-1];
      end

      assign trial = {rem_src, low_src[QUOT_BITS-1]};
      assign diff  = trial - {1'b0, den_src};
      assign ge    = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
            dlow_ff[k]  <= {low_src[QUOT_BITS-2:0], 1'b0};
            dden_ff[k]  <= den_src;
            dquo_ff[k]  <= {quo_src[QUOT_BITS-2:0], ge};
            dside_ff[k] <= side_src;
         end
      end
   end

   // ratio squared
   assign sq_full = ACC_BITS'(dquo_ff[QUOT_BITS-1]) * ACC_BITS'(dquo_ff[QUOT_BITS-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= sq_full[SQ_BITS-1:0];
         sq_q_ff  <= dquo_ff[QUOT_BITS-1];
         sside_ff <= dside_ff[QUOT_BITS-1];
      end
   end

   // horner steps in s, highest coefficient first
   for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
      coef_type             acc_src;
      logic [SQ_BITS-1:0]   s_src;
      logic [QUOT_BITS-1:0] q_src;
      side_type             side_src;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] rnd;

      if (h == 0) begin : g_first
         assign acc_src  = COEF_Q30[NUM_COEFS-1];
         assign s_src    = s_ff;
         assign q_src    = sq_q_ff;
         assign side_src = sside_ff;
      end else begin : g_next
         assign acc_src  = hacc_ff[h-1];
         assign s_src    = hs_ff[h-1];
         assign q_src    = hq_ff[h-1];
         assign side_src = hside_ff[h-1];
      end

      assign prod = acc_src * $signed({1'b0, s_src});
      assign rnd  = (prod + HALF_C) >>> COEF_FRAC;

      always_ff @(posedge clock) begin
         if (en) begin
            hacc_ff[h]  <= COEF_Q30[NUM_COEFS-2-h] + $signed(rnd[ACC_BITS-1:0]);
            hs_ff[h]    <= s_src;
            hq_ff[h]    <= q_src;
            hside_ff[h] <= side_src;
         end
      end
   end

   // magnitude q * acc
   assign mprod = $signed({1'b0, hq_ff[HORNER_STEPS-1]}) * hacc_ff[HORNER_STEPS-1];
   assign mrnd  = (mprod + HALF_M) >>> MSH;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= mrnd[AW-1:0];
         mside_ff <= hside_ff[HORNER_STEPS-1];
      end
   end

   // quadrant correction, modulo the angle width
   always_comb begin
      sgn_m  = mside_ff.neg ? (~m_ff + 1'b1) : m_ff;
      ang_in = sgn_m;
      if (mside_ff.swap) begin
         ang_in = (mside_ff.neg ? (~HALF_PI_Q + 1'b1) : HALF_PI_Q) - sgn_m;
      end
      if (mside_ff.x_neg) begin
         ang_in = mside_ff.y_neg ? (ang_in - PI_Q) : (ang_in + PI_Q);
      end
      if (mside_ff.zero) begin
         ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   // skid register on the result side
   always_comb begin
      if (skid_v_ff) begin
         skid_v_in = !rsp_chan.ready;
      end else begin
         skid_v_in = valid_ff[ST_R] && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_ff <= ang_ff;
      end
   end

   assign rsp_chan.valid = skid_v_ff || valid_ff[ST_R];
   assign rsp_chan.angle = skid_v_ff ? skid_ff : ang_ff;

endmodule
